### hdl/cid_pkg.sv
// ----------------------------------------------------------------------------
// cid_pkg
// shared types and constants of the compact index decoder
// ----------------------------------------------------------------------------
package cid_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned AccW    = 31;
  localparam int unsigned PosW    = 3;
  localparam int unsigned StatusW = 2;

  // first byte fields
  localparam int unsigned FirstSignBit = 7;
  localparam int unsigned FirstMoreBit = 6;
  localparam int unsigned FirstValW    = 6;

  // continuation byte fields
  localparam int unsigned NextMoreBit = 7;
  localparam int unsigned NextValW    = 7;

  // last continuation byte carries at most four payload bits
  localparam logic [NextValW-1:0] LastPayloadMax = 7'h0f;
  localparam logic [PosW-1:0]     LastPos        = 3'd4;
  localparam logic [PosW-1:0]     MaxBytes       = 3'd5;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic               valid;
    logic [ValueW-1:0]  value;
    status_e            status;
  } result_t;

endpackage

### hdl/cid_input_stage.sv
// ----------------------------------------------------------------------------
// cid_input_stage
// input register for one byte beat, held while the decoder cannot advance
// ----------------------------------------------------------------------------
module cid_input_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [cid_pkg::ByteW-1:0] data_byte_i,
  input  logic                      advance_i,
  output logic                      byte_valid_o,
  output logic [cid_pkg::ByteW-1:0] byte_o
);

  logic                      valid_q, valid_d;
  logic [cid_pkg::ByteW-1:0] byte_q;
  logic                      load;

  // free slot, or the held beat leaves this cycle
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= data_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

### hdl/cid_decode_core.sv
// ----------------------------------------------------------------------------
// cid_decode_core
// per-byte decode step with the accumulator, position and sign registers
// ----------------------------------------------------------------------------
module cid_decode_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [cid_pkg::ByteW-1:0] byte_i,
  output cid_pkg::result_t          result_o
);

  localparam int unsigned WideW = cid_pkg::AccW + cid_pkg::NextValW;

  logic [cid_pkg::AccW-1:0]     acc_q, acc_d;
  logic [cid_pkg::PosW-1:0]     pos_q, pos_d;
  logic                         sign_q, sign_d;

  logic                         first;
  logic [cid_pkg::NextValW-1:0] payload;
  logic                         more;
  logic [WideW-1:0]             shifted;
  logic [cid_pkg::AccW-1:0]     acc_next;
  logic [cid_pkg::AccW-1:0]     mag;
  logic                         neg;
  logic [cid_pkg::ValueW-1:0]   mag_ext;

  assign first   = (pos_q == '0) || (pos_q >= cid_pkg::MaxBytes);
  assign payload = byte_i[cid_pkg::NextValW-1:0];
  assign more    = byte_i[cid_pkg::NextMoreBit];

  // continuation payload placed above the bits gathered so far
  always_comb begin
    unique case (pos_q)
      3'd1:    shifted = {{(WideW-cid_pkg::NextValW){1'b0}}, payload} << 6;
      3'd2:    shifted = {{(WideW-cid_pkg::NextValW){1'b0}}, payload} << 13;
      3'd3:    shifted = {{(WideW-cid_pkg::NextValW){1'b0}}, payload} << 20;
      3'd4:    shifted = {{(WideW-cid_pkg::NextValW){1'b0}}, payload} << 27;
      default: shifted = '0;
    endcase
  end

  assign acc_next = acc_q | shifted[cid_pkg::AccW-1:0];

  always_comb begin
    acc_d           = acc_q;
    pos_d           = pos_q;
    sign_d          = sign_q;
    mag             = '0;
    neg             = 1'b0;
    result_o.valid  = 1'b0;
    result_o.status = cid_pkg::STATUS_OK;
    if (first) begin
      sign_d = byte_i[cid_pkg::FirstSignBit];
      acc_d  = {{(cid_pkg::AccW-cid_pkg::FirstValW){1'b0}},
                byte_i[cid_pkg::FirstValW-1:0]};
      if (!byte_i[cid_pkg::FirstMoreBit]) begin
        result_o.valid = 1'b1;
        mag            = acc_d;
        neg            = sign_d;
      end else begin
        pos_d = 3'd1;
      end
    end else if ((pos_q == cid_pkg::LastPos) && (payload > cid_pkg::LastPayloadMax)) begin
      result_o.valid  = 1'b1;
      result_o.status = cid_pkg::STATUS_OVERFLOW;
    end else if (!more) begin
      result_o.valid = 1'b1;
      mag            = acc_next;
      neg            = sign_q;
    end else if (pos_q == cid_pkg::LastPos) begin
      result_o.valid  = 1'b1;
      result_o.status = cid_pkg::STATUS_TOO_LONG;
    end else begin
      acc_d = acc_next;
      pos_d = pos_q + 3'd1;
    end
    // every result restarts decoding
    if (result_o.valid) begin
      acc_d  = '0;
      pos_d  = '0;
      sign_d = 1'b0;
    end
    mag_ext        = {1'b0, mag};
    result_o.value = neg ? (~mag_ext + 32'd1) : mag_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pos_q  <= '0;
      sign_q <= 1'b0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      pos_q  <= pos_d;
      sign_q <= sign_d;
    end
  end

endmodule

### hdl/cid_output_stage.sv
// ----------------------------------------------------------------------------
// cid_output_stage
// result register towards the receiver
// ----------------------------------------------------------------------------
module cid_output_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  cid_pkg::result_t                   result_i,
  output logic                               free_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [cid_pkg::ValueW-1:0]  value_o,
  output logic [cid_pkg::StatusW-1:0]        status_o
);

  logic                        valid_q, valid_d;
  logic [cid_pkg::ValueW-1:0]  value_q;
  cid_pkg::status_e            status_q;
  logic                        write;

  // slot is free when empty or its beat is taken this cycle
  assign free_o = !valid_q || !out_stall_i;
  assign write  = load_i && result_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (write) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write) begin
      value_q  <= result_i.value;
      status_q <= result_i.status;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

### hdl/compact_index_decoder_unit.sv
// ----------------------------------------------------------------------------
// compact_index_decoder_unit
// signed compact index decoder, unless stalled one byte beat per cycle
// ----------------------------------------------------------------------------
// usage
//   input channel : in_valid_i / in_stall_o with data_byte_i, one stream byte
//                   per beat; the first byte of an integer holds sign, continue
//                   flag and six value bits, later bytes seven bits each
//   output channel: out_valid_o / out_stall_i with value_o and status_o;
//                   one beat per finished integer or per error
//   status        : ok, overflow in the fourth continuation byte, or too long;
//                   value is zero for errors and decoding restarts at the next
//                   byte
//   path          : an accepted byte waits in the input register; the decode
//                   step then fills the result register, which offers it
//   throughput    : one byte per cycle while the result register is free,
//                   set by the single decode step between the two registers
//   stall         : while the result register is full and stalled, the decode
//                   step holds; the input register still takes one more byte
//                   if it is empty, then in_stall_o rises
//   reset         : rst_ni clears both valid flags and the decode state, so
//                   the next byte is taken as a first byte
// ----------------------------------------------------------------------------
module compact_index_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [cid_pkg::ByteW-1:0]          data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [cid_pkg::ValueW-1:0]  value_o,
  output logic [cid_pkg::StatusW-1:0]        status_o
);

  logic                      byte_valid;
  logic [cid_pkg::ByteW-1:0] byte_held;
  logic                      out_free;
  logic                      step;
  cid_pkg::result_t          result;

  // a held byte is decoded when the result slot can take what it may produce
  assign step = byte_valid && out_free;

  cid_input_stage u_input (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .advance_i    (step),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_held)
  );

  cid_decode_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (byte_held),
    .result_o (result)
  );

  cid_output_stage u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  // error beats carry a zero value
  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != cid_pkg::STATUS_OK)) |-> (value_o == '0))
    else $error("error beat with non-zero value");

  // only the three defined status codes leave the block
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == cid_pkg::STATUS_OK) ||
                     (status_o == cid_pkg::STATUS_OVERFLOW) ||
                     (status_o == cid_pkg::STATUS_TOO_LONG)))
    else $error("undefined status code");

  // input back-pressure only comes from a stalled full result register
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule
